>>> hw/rtl/totp_pkg.sv
package totp_pkg;

  localparam int DEFAULT_CODE_DIGITS  = 6;
  localparam int DEFAULT_STEP_SECONDS = 30;

  localparam int KEY_WORDS = 8;

  localparam logic [31:0] IPAD_WORD = 32'h3636_3636;
  localparam logic [31:0] OPAD_WORD = 32'h5c5c_5c5c;
  localparam logic [31:0] PAD_WORD  = 32'h8000_0000;

  // Message lengths in bits: key block plus counter, key block plus inner digest.
  localparam logic [31:0] INNER_LEN_BITS = 32'd576;
  localparam logic [31:0] OUTER_LEN_BITS = 32'd672;

  localparam logic [31:0] IV0 = 32'h6745_2301;
  localparam logic [31:0] IV1 = 32'hefcd_ab89;
  localparam logic [31:0] IV2 = 32'h98ba_dcfe;
  localparam logic [31:0] IV3 = 32'h1032_5476;
  localparam logic [31:0] IV4 = 32'hc3d2_e1f0;

  localparam logic [31:0] K0 = 32'h5a82_7999;
  localparam logic [31:0] K1 = 32'h6ed9_eba1;
  localparam logic [31:0] K2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K3 = 32'hca62_c1d6;

  localparam logic [1:0] BLK_INNER_KEY = 2'd0;
  localparam logic [1:0] BLK_INNER_MSG = 2'd1;
  localparam logic [1:0] BLK_OUTER_KEY = 2'd2;
  localparam logic [1:0] BLK_OUTER_MSG = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_TRUNC,
    S_MOD,
    S_DONE
  } state_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

>>> hw/rtl/totp_hmac_sha1_code_unit.sv
// One-time code unit: HMAC-SHA1 over the time step, then dynamic truncation.
// The key is written as eight 64-bit words over the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always high and
// writes to an index of eight or more are ignored. The user must write keys
// only while the unit is idle; the unit itself does not enforce this. A
// transaction on the input channel carries unix_seconds; one transaction on
// the output channel returns otp_code for it. For each item the unit divides
// by the step length with a reciprocal in the shared 32 by 32 multiplier and
// one correction, runs four SHA-1 compressions of 80 rounds plus a load and a
// feed-forward step each, takes a truncation step, does a modular reduction
// in the same multiplier, and ends in a final state. The single SHA-1 round
// datapath sets the bulk of the processing time. in_ready is high only while
// the unit is idle, so one item is in work at a time.
// The result sits in an output register; if the receiver stalls, the unit
// may still accept and compute the next item, but holds it in its final
// state until the previous result has been taken. Synchronous reset clears
// the key to zero and empties the unit.
module totp_hmac_sha1_code_unit
  import totp_pkg::*;
#(
  parameter int CODE_DIGITS  = DEFAULT_CODE_DIGITS,
  parameter int STEP_SECONDS = DEFAULT_STEP_SECONDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] unix_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] otp_code
);

  localparam longint unsigned MODULUS = pow10(CODE_DIGITS);
  localparam logic [63:0] STEP_D     = 64'(STEP_SECONDS);
  localparam logic [63:0] MOD_D      = 64'(MODULUS);
  localparam logic [63:0] STEP_RECIP = {64{1'b1}} / STEP_D;
  localparam logic [63:0] MOD_RECIP  = {64{1'b1}} / MOD_D;
  localparam logic [6:0]  DIV_LAST   = 7'd5;

  state_t state, state_next;

  logic [63:0] key_word [KEY_WORDS];
  logic [6:0]  cnt;
  logic [1:0]  blk;
  logic [63:0] num;
  logic [65:0] acc;
  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] w [16];
  logic [31:0] h [5];
  logic [31:0] hin [5];
  logic [31:0] a, b, c, d, e;

  logic [63:0]   recip;
  logic [31:0]   divisor, mul_a, mul_b, rem_diff;
  logic [63:0]   product;
  logic [65:0]   acc_sum;
  logic          rem_fix;
  logic [31:0]   f, k, tmp, w_new;
  logic [159:0]  digest;
  logic [31:0]   bin;
  logic [31:0]   blk_word [16];
  logic          out_free;

  // Shared multiplier: the quotient is the high half of the dividend times a
  // reciprocal, which is at most one too small and is fixed in the last step.
  always_comb begin
    recip   = (state == S_DIV) ? STEP_RECIP : MOD_RECIP;
    divisor = (state == S_DIV) ? STEP_D[31:0] : MOD_D[31:0];
    unique case (cnt)
      7'd1: begin
        mul_a = num[63:32];
        mul_b = recip[31:0];
      end
      7'd2: begin
        mul_a = num[31:0];
        mul_b = recip[63:32];
      end
      7'd3: begin
        mul_a = num[63:32];
        mul_b = recip[63:32];
      end
      7'd4: begin
        mul_a = quo[31:0];
        mul_b = divisor;
      end
      default: begin
        mul_a = num[31:0];
        mul_b = recip[31:0];
      end
    endcase
    product = {32'd0, mul_a} * {32'd0, mul_b};
    unique case (cnt)
      7'd1, 7'd3: acc_sum = {32'd0, acc[65:32]} + {2'd0, product};
      7'd2:       acc_sum = acc + {2'd0, product};
      default:    acc_sum = {2'd0, product};
    endcase
    rem_diff = num[31:0] - product[31:0];
    rem_fix  = (rem >= divisor);
  end

  // SHA-1 round.
  always_comb begin
    priority if (cnt < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (cnt < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (cnt < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    tmp   = rotl(a, 5) + f + e + k + w[0];
    w_new = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
  end

  // Message block words.
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      blk_word[j] = '0;
    end
    unique case (blk)
      BLK_INNER_KEY: begin
        for (int j = 0; j < 16; j++) begin
          blk_word[j] = (j % 2 == 0) ? key_word[j/2][63:32] ^ IPAD_WORD
                                     : key_word[j/2][31:0] ^ IPAD_WORD;
        end
      end
      BLK_OUTER_KEY: begin
        for (int j = 0; j < 16; j++) begin
          blk_word[j] = (j % 2 == 0) ? key_word[j/2][63:32] ^ OPAD_WORD
                                     : key_word[j/2][31:0] ^ OPAD_WORD;
        end
      end
      BLK_INNER_MSG: begin
        blk_word[0]  = quo[63:32];
        blk_word[1]  = quo[31:0];
        blk_word[2]  = PAD_WORD;
        blk_word[15] = INNER_LEN_BITS;
      end
      BLK_OUTER_MSG: begin
        for (int j = 0; j < 5; j++) begin
          blk_word[j] = hin[j];
        end
        blk_word[5]  = PAD_WORD;
        blk_word[15] = OUTER_LEN_BITS;
      end
      default: begin
      end
    endcase
  end

  // Dynamic truncation.
  always_comb begin
    digest = {h[0], h[1], h[2], h[3], h[4]};
    bin    = 32'(digest >> (8'd128 - {1'b0, h[4][3:0], 3'b000}));
    bin[31] = 1'b0;
  end

  always_comb begin
    out_free = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_DIV;
      S_DIV:   if (cnt == DIV_LAST) state_next = S_LOAD;
      S_LOAD:  state_next = S_ROUND;
      S_ROUND: if (cnt == 7'd79) state_next = S_ADD;
      S_ADD: begin
        state_next = (blk == BLK_OUTER_MSG) ? S_TRUNC : S_LOAD;
      end
      S_TRUNC: state_next = S_MOD;
      S_MOD:   if (cnt == DIV_LAST) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_word[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < 8'(KEY_WORDS)) begin
      key_word[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      otp_code <= rem[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      blk <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          blk <= BLK_INNER_KEY;
        end
        S_DIV, S_ROUND, S_MOD: cnt <= cnt + 7'd1;
        S_LOAD, S_TRUNC: cnt <= '0;
        S_ADD: blk <= blk + 2'd1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        num <= unix_seconds;
      end
      S_DIV, S_MOD: begin
        priority if (cnt < 7'd3) begin
          acc <= acc_sum;
        end else if (cnt == 7'd3) begin
          quo <= acc_sum[63:0];
        end else if (cnt == 7'd4) begin
          rem <= rem_diff;
        end else if (rem_fix) begin
          rem <= rem - divisor;
          quo <= quo + 64'd1;
        end
      end
      S_TRUNC: begin
        num <= {33'd0, bin[30:0]};
      end
      S_LOAD: begin
        for (int j = 0; j < 16; j++) begin
          w[j] <= blk_word[j];
        end
        if (!blk[0]) begin
          h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
          a <= IV0; b <= IV1; c <= IV2; d <= IV3; e <= IV4;
        end else begin
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
        end
      end
      S_ROUND: begin
        for (int j = 0; j < 15; j++) begin
          w[j] <= w[j+1];
        end
        w[15] <= w_new;
        e <= d;
        d <= c;
        c <= rotl(b, 30);
        b <= a;
        a <= tmp;
      end
      S_ADD: begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
        if (blk == BLK_INNER_MSG) begin
          hin[0] <= h[0] + a;
          hin[1] <= h[1] + b;
          hin[2] <= h[2] + c;
          hin[3] <= h[3] + d;
          hin[4] <= h[4] + e;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
